// ----- src/inverted_page_table_unit_top_defines.svh -----
// Assertion macros for the top level of the inverted page table unit.
`ifndef INVERTED_PAGE_TABLE_UNIT_TOP_DEFINES_SVH
`define INVERTED_PAGE_TABLE_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IPT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IPT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define IPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/ipt_pkg.sv -----
`default_nettype none
package ipt_pkg;

  localparam int REQ_W   = 2;
  localparam int PID_W   = 8;
  localparam int KIND_W  = 3;
  localparam int ADDR_W  = 32;
  localparam int FRAME_W = 8;
  localparam int PHYS_W  = 20;
  localparam int OFFS_W  = 12;

  localparam logic [ADDR_W-1:0] PAGE_BYTES = 32'd4096;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_XLATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SHIFT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_HEAP  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STACK = 3'd5;

  typedef struct packed {
    logic cnt_rst;
    logic cnt_inc;
    logic clr_wr;
    logic scan_rd;
    logic start;
    logic fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ----- src/ipt_ctrl.sv -----
`default_nettype none
module ipt_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  ipt_pkg::ctrl_sts_t   sts_i,
  output ipt_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.clear_last) begin
          cmd_o.cnt_rst = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.cnt_rst = 1'b1;
          state_d       = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fire = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- src/ipt_datapath.sv -----
`default_nettype none
module ipt_datapath #(
  parameter int PAGES     = 256,
  parameter int PROCESSES = 256
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  ipt_pkg::ctrl_cmd_t                   cmd_i,
  output ipt_pkg::ctrl_sts_t                   sts_o,
  input  wire  [ipt_pkg::REQ_W-1:0]            req_type_i,
  input  wire  [ipt_pkg::PID_W-1:0]            process_id_i,
  input  wire  [ipt_pkg::KIND_W-1:0]           page_kind_i,
  input  wire  [ipt_pkg::ADDR_W-1:0]           logical_addr_i,
  input  wire                                  grow_heap_i,
  output logic                                 status_o,
  output logic [ipt_pkg::FRAME_W-1:0]          frame_index_o,
  output logic [ipt_pkg::ADDR_W-1:0]           logical_start_o,
  output logic [ipt_pkg::PHYS_W-1:0]           physical_addr_o
);

  localparam int IW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int PW   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int MAXD = (PAGES > PROCESSES) ? PAGES : PROCESSES;
  localparam int CW   = $clog2(MAXD);
  localparam int CW1  = CW + 1;
  localparam int PIDW1 = ipt_pkg::PID_W + 1;

  typedef struct packed {
    logic                          used;
    logic [ipt_pkg::PID_W-1:0]     owner;
    logic [ipt_pkg::KIND_W-1:0]    kind;
    logic [ipt_pkg::ADDR_W-1:0]    base;
  } entry_t;

  entry_t                     frame_mem [PAGES];
  logic [ipt_pkg::ADDR_W-1:0] next_mem  [PROCESSES];

  logic [CW-1:0]                cnt_q;
  logic                         rd_vld_q;
  logic [IW-1:0]                rd_idx_q;
  entry_t                       rd_data_q;
  logic [ipt_pkg::ADDR_W-1:0]   next_q;

  logic [ipt_pkg::REQ_W-1:0]    req_q;
  logic [ipt_pkg::PID_W-1:0]    pid_q;
  logic [ipt_pkg::KIND_W-1:0]   kind_q;
  logic [ipt_pkg::ADDR_W-1:0]   addr_q;
  logic                         grow_q;

  logic                         found_q;
  logic [IW-1:0]                best_q;
  logic [ipt_pkg::ADDR_W-1:0]   best_base_q;

  logic                         status_q;
  logic [ipt_pkg::FRAME_W-1:0]  frame_q;
  logic [ipt_pkg::ADDR_W-1:0]   lstart_q;
  logic [ipt_pkg::PHYS_W-1:0]   phys_q;

  logic                         hit;
  logic                         pid_bad;
  logic                         ok;
  logic [ipt_pkg::KIND_W-1:0]   want_kind;
  logic [ipt_pkg::KIND_W-1:0]   new_kind;
  logic [ipt_pkg::ADDR_W-1:0]   diff;
  logic [ipt_pkg::FRAME_W-1:0]  fidx;
  logic                         fm_we;
  logic [IW-1:0]                fm_waddr;
  entry_t                       fm_wdata;
  logic                         nm_we;
  logic [PW-1:0]                nm_waddr;
  logic [ipt_pkg::ADDR_W-1:0]   nm_wdata;

  assign sts_o.clear_last = (cnt_q == CW'(MAXD - 1));
  assign sts_o.scan_last  = (cnt_q == CW'(PAGES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.cnt_rst) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (rd_vld_q && hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q  <= req_type_i;
      pid_q  <= process_id_i;
      kind_q <= page_kind_i;
      addr_q <= logical_addr_i;
      grow_q <= grow_heap_i;
    end
    if (rd_vld_q && hit) begin
      best_q      <= rd_idx_q;
      best_base_q <= rd_data_q.base;
    end
    rd_idx_q <= cnt_q[IW-1:0];
  end

  // Frame table: one read port for the scan, one write port.
  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      frame_mem[fm_waddr] <= fm_wdata;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= frame_mem[cnt_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nm_we) begin
      next_mem[nm_waddr] <= nm_wdata;
    end
    next_q <= next_mem[pid_q[PW-1:0]];
  end

  assign want_kind = grow_q ? ipt_pkg::KIND_STACK : ipt_pkg::KIND_HEAP;
  assign new_kind  = grow_q ? ipt_pkg::KIND_HEAP : ipt_pkg::KIND_STACK;
  assign diff      = addr_q - rd_data_q.base;

  always_comb begin
    hit = 1'b0;
    case (req_q)
      ipt_pkg::REQ_ALLOC: begin
        hit = !found_q && !rd_data_q.used;
      end
      ipt_pkg::REQ_XLATE: begin
        hit = !found_q && rd_data_q.used && (rd_data_q.owner == pid_q) &&
              (diff[ipt_pkg::ADDR_W-1:ipt_pkg::OFFS_W] == '0);
      end
      ipt_pkg::REQ_SHIFT: begin
        hit = rd_data_q.used && (rd_data_q.owner == pid_q) &&
              (rd_data_q.kind == want_kind) &&
              (!found_q || (grow_q ? (rd_data_q.base < best_base_q)
                                   : (rd_data_q.base > best_base_q)));
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign pid_bad = ({1'b0, pid_q} >= PIDW1'(PROCESSES));
  assign ok      = !pid_bad && found_q;
  assign fidx    = ipt_pkg::FRAME_W'(best_q);

  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = best_q;
    fm_wdata = '{used: 1'b1, owner: pid_q, kind: kind_q, base: next_q};
    nm_we    = 1'b0;
    nm_waddr = pid_q[PW-1:0];
    nm_wdata = next_q + ipt_pkg::PAGE_BYTES;
    if (cmd_i.clr_wr) begin
      fm_we    = ({1'b0, cnt_q} < CW1'(PAGES));
      fm_waddr = cnt_q[IW-1:0];
      fm_wdata = '0;
      nm_we    = ({1'b0, cnt_q} < CW1'(PROCESSES));
      nm_waddr = cnt_q[PW-1:0];
      nm_wdata = '0;
    end else if (cmd_i.fire && ok) begin
      case (req_q)
        ipt_pkg::REQ_ALLOC: begin
          fm_we = 1'b1;
          nm_we = 1'b1;
        end
        ipt_pkg::REQ_SHIFT: begin
          fm_we    = 1'b1;
          fm_wdata = '{used: 1'b1, owner: pid_q, kind: new_kind, base: best_base_q};
        end
        default: begin
          fm_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      if (!ok) begin
        status_q <= 1'b1;
        frame_q  <= '0;
        lstart_q <= '0;
        phys_q   <= '0;
      end else begin
        status_q <= 1'b0;
        frame_q  <= fidx;
        if (req_q == ipt_pkg::REQ_ALLOC) begin
          lstart_q <= next_q;
        end else begin
          lstart_q <= best_base_q;
        end
        if (req_q == ipt_pkg::REQ_XLATE) begin
          phys_q <= {fidx, addr_q[ipt_pkg::OFFS_W-1:0]};
        end else begin
          phys_q <= {fidx, {ipt_pkg::OFFS_W{1'b0}}};
        end
      end
    end
  end

  assign status_o        = status_q;
  assign frame_index_o   = frame_q;
  assign logical_start_o = lstart_q;
  assign physical_addr_o = phys_q;

endmodule
`default_nettype wire

// ----- src/inverted_page_table_unit_top.sv -----
// Inverted page table of PAGES frames of 4096 bytes, frame i at physical address i*4096.
// Requests are allocate, translate and shift of the heap-stack boundary by one page,
// and each word accepted gives exactly one result word, with status 1 on any failure
// and the other fields then zero. After reset a clearing pass over max(PAGES, PROCESSES)
// entries empties the frame table and the per-process next addresses, and no request is
// taken until it is done. Each request then scans the whole frame table through its
// single read port, one entry a cycle, and a new request is taken only once the last
// one's result has been loaded. The result sits in an output register, so the next
// request may already be scanning while a result waits to be taken.
`default_nettype none
`include "inverted_page_table_unit_top_defines.svh"
module inverted_page_table_unit_top #(
  parameter int PAGES     = 256,
  parameter int PROCESSES = 256
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [ipt_pkg::REQ_W-1:0]            req_type_i,
  input  wire  [ipt_pkg::PID_W-1:0]            process_id_i,
  input  wire  [ipt_pkg::KIND_W-1:0]           page_kind_i,
  input  wire  [ipt_pkg::ADDR_W-1:0]           logical_addr_i,
  input  wire                                  grow_heap_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic                                 status_o,
  output logic [ipt_pkg::FRAME_W-1:0]          frame_index_o,
  output logic [ipt_pkg::ADDR_W-1:0]           logical_start_o,
  output logic [ipt_pkg::PHYS_W-1:0]           physical_addr_o
);

  ipt_pkg::ctrl_cmd_t ctrl_cmd;
  ipt_pkg::ctrl_sts_t ctrl_sts;

  ipt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (ctrl_sts),
    .cmd_o       (ctrl_cmd)
  );

  ipt_datapath #(
    .PAGES     (PAGES),
    .PROCESSES (PROCESSES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .sts_o           (ctrl_sts),
    .req_type_i      (req_type_i),
    .process_id_i    (process_id_i),
    .page_kind_i     (page_kind_i),
    .logical_addr_i  (logical_addr_i),
    .grow_heap_i     (grow_heap_i),
    .status_o        (status_o),
    .frame_index_o   (frame_index_o),
    .logical_start_o (logical_start_o),
    .physical_addr_o (physical_addr_o)
  );

  `IPT_ASSERT_NEXT(a_one_request, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `IPT_ASSERT_SAME(a_result_from_fire, clk_i, rst_ni, $rose(out_valid_o), $past(ctrl_cmd.fire))
  `IPT_ASSERT_SAME(a_no_accept_in_clear, clk_i, rst_ni, ctrl_cmd.clr_wr, !in_ready_o)

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int PAGES = 256;
  localparam int PROCESSES = 256;
  localparam int STALL_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 2 * PAGES + 16;

  localparam logic [ipt_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [ipt_pkg::KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [ipt_pkg::KIND_W-1:0] KIND_CODE = 3'd1;
  localparam logic [ipt_pkg::KIND_W-1:0] KIND_DATA = 3'd2;
  localparam logic [ipt_pkg::KIND_W-1:0] KIND_TEXT = 3'd3;
  localparam logic [ipt_pkg::KIND_W-1:0] KIND_ODD  = 3'd7;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [ipt_pkg::PID_W-1:0] PID_MAX = ipt_pkg::PID_W'(PROCESSES - 1);

  typedef struct packed {
    logic                         status;
    logic [ipt_pkg::FRAME_W-1:0]  frame;
    logic [ipt_pkg::ADDR_W-1:0]   lstart;
    logic [ipt_pkg::PHYS_W-1:0]   phys;
  } page_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [ipt_pkg::REQ_W-1:0]    req_type_i;
  logic [ipt_pkg::PID_W-1:0]    process_id_i;
  logic [ipt_pkg::KIND_W-1:0]   page_kind_i;
  logic [ipt_pkg::ADDR_W-1:0]   logical_addr_i;
  logic                         grow_heap_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic                         status_o;
  logic [ipt_pkg::FRAME_W-1:0]  frame_index_o;
  logic [ipt_pkg::ADDR_W-1:0]   logical_start_o;
  logic [ipt_pkg::PHYS_W-1:0]   physical_addr_o;

  bit                           table_used  [PAGES];
  logic [ipt_pkg::PID_W-1:0]    table_owner [PAGES];
  logic [ipt_pkg::KIND_W-1:0]   table_kind  [PAGES];
  logic [ipt_pkg::ADDR_W-1:0]   table_base  [PAGES];
  logic [ipt_pkg::ADDR_W-1:0]   proc_next_addr [PROCESSES];
  int                           frames_taken;

  page_result_t        pending_results[$];
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  stall_request = 0;

  inverted_page_table_unit_top #(
    .PAGES     (PAGES),
    .PROCESSES (PROCESSES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .process_id_i    (process_id_i),
    .page_kind_i     (page_kind_i),
    .logical_addr_i  (logical_addr_i),
    .grow_heap_i     (grow_heap_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_index_o   (frame_index_o),
    .logical_start_o (logical_start_o),
    .physical_addr_o (physical_addr_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_table_model();
    for (int i = 0; i < PAGES; i++) begin
      table_used[i]  = 1'b0;
      table_owner[i] = '0;
      table_kind[i]  = KIND_NONE;
      table_base[i]  = '0;
    end
    for (int p = 0; p < PROCESSES; p++) begin
      proc_next_addr[p] = '0;
    end
    frames_taken = 0;
  endfunction

  function automatic page_result_t serve_request(
    input logic [ipt_pkg::REQ_W-1:0]  req,
    input logic [ipt_pkg::PID_W-1:0]  pid,
    input logic [ipt_pkg::KIND_W-1:0] kind,
    input logic [ipt_pkg::ADDR_W-1:0] addr,
    input logic                       grow
  );
    page_result_t                 res;
    logic [ipt_pkg::KIND_W-1:0]   want;
    logic                         found;
    int                           best;
    res = '0;
    res.status = STATUS_FAIL;
    found = 1'b0;
    best = 0;
    want = grow ? ipt_pkg::KIND_STACK : ipt_pkg::KIND_HEAP;
    case (req)
      ipt_pkg::REQ_ALLOC: begin
        for (int i = 0; i < PAGES; i++) begin
          if (!found && !table_used[i]) begin
            found = 1'b1;
            best = i;
          end
        end
        if (found) begin
          table_used[best]  = 1'b1;
          table_owner[best] = pid;
          table_kind[best]  = kind;
          table_base[best]  = proc_next_addr[pid];
          proc_next_addr[pid] = proc_next_addr[pid] + ipt_pkg::PAGE_BYTES;
          frames_taken++;
          res.status = STATUS_OK;
          res.frame  = best[ipt_pkg::FRAME_W-1:0];
          res.lstart = table_base[best];
          res.phys   = {best[ipt_pkg::FRAME_W-1:0], {ipt_pkg::OFFS_W{1'b0}}};
        end
      end
      ipt_pkg::REQ_XLATE: begin
        for (int i = 0; i < PAGES; i++) begin
          if (!found && table_used[i] && table_owner[i] == pid &&
              (addr - table_base[i]) < ipt_pkg::PAGE_BYTES) begin
            found = 1'b1;
            best = i;
          end
        end
        if (found) begin
          res.status = STATUS_OK;
          res.frame  = best[ipt_pkg::FRAME_W-1:0];
          res.lstart = table_base[best];
          res.phys   = {best[ipt_pkg::FRAME_W-1:0], addr[ipt_pkg::OFFS_W-1:0]};
        end
      end
      ipt_pkg::REQ_SHIFT: begin
        for (int i = 0; i < PAGES; i++) begin
          if (table_used[i] && table_owner[i] == pid && table_kind[i] == want) begin
            if (!found || (grow ? (table_base[i] < table_base[best])
                                : (table_base[i] > table_base[best]))) begin
              found = 1'b1;
              best = i;
            end
          end
        end
        if (found) begin
          table_kind[best] = grow ? ipt_pkg::KIND_HEAP : ipt_pkg::KIND_STACK;
          res.status = STATUS_OK;
          res.frame  = best[ipt_pkg::FRAME_W-1:0];
          res.lstart = table_base[best];
          res.phys   = {best[ipt_pkg::FRAME_W-1:0], {ipt_pkg::OFFS_W{1'b0}}};
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic send_request(
    input logic [ipt_pkg::REQ_W-1:0]  req,
    input logic [ipt_pkg::PID_W-1:0]  pid,
    input logic [ipt_pkg::KIND_W-1:0] kind,
    input logic [ipt_pkg::ADDR_W-1:0] addr,
    input logic                       grow
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    process_id_i   <= pid;
    page_kind_i    <= kind;
    logical_addr_i <= addr;
    grow_heap_i    <= grow;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(serve_request(req, pid, kind, addr, grow));
  endtask

  task automatic check_field(input string name, input logic [ipt_pkg::ADDR_W-1:0] exp_v,
                             input logic [ipt_pkg::ADDR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin : result_checker
    int           stall_left;
    page_result_t want;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none, actual %0h %0h %0h %0h",
                   $time, status_o, frame_index_o, logical_start_o, physical_addr_o);
        end else begin
          want = pending_results.pop_front();
          check_field("status", ipt_pkg::ADDR_W'(want.status),
                      ipt_pkg::ADDR_W'(status_o));
          check_field("frame_index", ipt_pkg::ADDR_W'(want.frame),
                      ipt_pkg::ADDR_W'(frame_index_o));
          check_field("logical_start", want.lstart, logical_start_o);
          check_field("physical_addr", ipt_pkg::ADDR_W'(want.phys),
                      ipt_pkg::ADDR_W'(physical_addr_o));
        end
      end
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_random_request();
    logic [ipt_pkg::REQ_W-1:0]  req;
    logic [ipt_pkg::PID_W-1:0]  pid;
    logic [ipt_pkg::KIND_W-1:0] kind;
    logic [ipt_pkg::ADDR_W-1:0] addr;
    logic                       grow;
    int                         pick;
    int                         frame;
    pid  = ($urandom_range(0, 99) < 80) ? ipt_pkg::PID_W'($urandom_range(0, 7))
                                        : ipt_pkg::PID_W'($urandom_range(0, 255));
    kind = ipt_pkg::KIND_W'($urandom_range(0, 7));
    addr = $urandom;
    grow = 1'($urandom_range(0, 1));
    pick = int'($urandom_range(0, 99));
    if (pick < 35) begin
      req = ipt_pkg::REQ_ALLOC;
      pick = int'($urandom_range(0, 99));
      if (pick < 40) begin
        kind = ipt_pkg::KIND_HEAP;
      end else if (pick < 80) begin
        kind = ipt_pkg::KIND_STACK;
      end
    end else if (pick < 75) begin
      req = ipt_pkg::REQ_XLATE;
      if (frames_taken > 0 && $urandom_range(0, 99) < 75) begin
        frame = int'($urandom_range(0, frames_taken - 1));
        pid  = table_owner[frame];
        addr = table_base[frame] + ipt_pkg::ADDR_W'($urandom_range(0, 4095));
      end
    end else if (pick < 95) begin
      req = ipt_pkg::REQ_SHIFT;
    end else begin
      req = REQ_UNKNOWN;
    end
    send_request(req, pid, kind, addr, grow);
  endtask

  task automatic test_allocate();
    send_request(ipt_pkg::REQ_ALLOC, 8'd0, ipt_pkg::KIND_STACK, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_ALLOC, 8'd0, ipt_pkg::KIND_STACK, 32'hFFFF_FFFF, 1'b1);
    send_request(ipt_pkg::REQ_ALLOC, 8'd0, ipt_pkg::KIND_HEAP, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_ALLOC, 8'd0, ipt_pkg::KIND_HEAP, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_ALLOC, 8'd0, KIND_CODE, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_ALLOC, 8'd0, KIND_ODD, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_ALLOC, 8'd0, KIND_NONE, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_ALLOC, PID_MAX, KIND_DATA, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_ALLOC, PID_MAX, KIND_TEXT, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_translate();
    send_request(ipt_pkg::REQ_XLATE, 8'd0, KIND_NONE, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_XLATE, 8'd0, KIND_NONE, 32'h0000_1FFF, 1'b0);
    send_request(ipt_pkg::REQ_XLATE, 8'd0, KIND_NONE, 32'h0000_6ABC, 1'b0);
    send_request(ipt_pkg::REQ_XLATE, 8'd0, KIND_NONE, 32'h0000_7000, 1'b0);
    send_request(ipt_pkg::REQ_XLATE, PID_MAX, KIND_ODD, 32'h0000_1FFF, 1'b1);
    send_request(ipt_pkg::REQ_XLATE, 8'd1, KIND_NONE, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_XLATE, 8'd0, KIND_NONE, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_shift();
    send_request(ipt_pkg::REQ_SHIFT, 8'd0, KIND_NONE, 32'h0000_0000, 1'b1);
    send_request(ipt_pkg::REQ_SHIFT, 8'd0, KIND_NONE, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_SHIFT, 8'd0, KIND_NONE, 32'h0000_0000, 1'b0);
    send_request(ipt_pkg::REQ_SHIFT, 8'd0, KIND_NONE, 32'h0000_0000, 1'b1);
    send_request(ipt_pkg::REQ_SHIFT, 8'd1, KIND_NONE, 32'h0000_0000, 1'b1);
    send_request(ipt_pkg::REQ_SHIFT, PID_MAX, KIND_NONE, 32'h0000_0000, 1'b0);
  endtask

  task automatic test_unknown_request();
    send_request(REQ_UNKNOWN, 8'd0, KIND_ODD, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 7;
    recv_idle_pct = 78;
    repeat (450) send_random_request();
    send_idle_pct = 78;
    recv_idle_pct = 7;
    repeat (450) send_random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (400) send_random_request();
  endtask

  // The receiver holds off while words keep coming, so the input has to stall.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = STALL_CYCLES;
    repeat (12) send_random_request();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    req_type_i     <= ipt_pkg::REQ_ALLOC;
    process_id_i   <= '0;
    page_kind_i    <= KIND_NONE;
    logical_addr_i <= '0;
    grow_heap_i    <= 1'b0;
    clear_table_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 7;
    recv_idle_pct = 78;
    test_allocate();
    test_translate();
    test_shift();
    test_unknown_request();
    test_random_traffic();
    test_output_stall();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
